// ----- rtl/core/wstfd_pkg.sv -----
// Shared types and constants for the websocket text frame decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wstfd_pkg;

    typedef enum logic [4:0] {
        PH_FIRST   = 5'b00001,
        PH_SECOND  = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } t_phase;

    localparam logic [1:0] ST_PAYLOAD = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    localparam logic [7:0] FIRST_HDR  = 8'h81;
    localparam logic [6:0] LEN_EXT16  = 7'd126;
    localparam logic [6:0] LEN_EXT64  = 7'd127;

    localparam logic [2:0] EXT16_CNT  = 3'd1;
    localparam logic [2:0] EXT64_CNT  = 3'd7;
    localparam logic [2:0] KEY_CNT    = 3'd3;

endpackage
`default_nettype wire

// ----- rtl/core/websocket_text_frame_decoder_top.sv -----
// Websocket text frame decoder: header parse, length, mask key and payload unmasking.
// Depends on wstfd_pkg.
//
// Takes one received byte per beat and accepts a new byte every cycle while the
// result side keeps up; a result held by i_out_stall holds the input register and so
// stalls the input. Each byte passes an input register and the state update and
// unmasking logic, and lands in a result register that drives the outputs. The
// per-byte state update, with its LENGTH_BITS-wide decrement and zero test, sets
// the cycle time. Header, length and key bytes give no result beat, except that the
// last of them gives one empty beat for a zero-length frame; a bad first header
// byte gives one status beat.
`timescale 1ns / 1ps
`default_nettype none
module websocket_text_frame_decoder_top #(
    parameter int LENGTH_BITS = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_stream_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_data_byte,
    output logic            o_is_last,
    output logic [1:0]      o_status
);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;

    wstfd_pkg::t_phase      r_phase, n_phase;
    logic [2:0]             r_hcnt, n_hcnt;
    logic [31:0]            r_key, n_key;
    logic                   r_mask_on, n_mask_on;
    logic [LENGTH_BITS-1:0] r_left, n_left;
    logic [1:0]             r_kidx, n_kidx;

    logic                   r_out_valid;
    logic [7:0]             r_data;
    logic                   r_last;
    logic [1:0]             r_status;

    logic                   w_adv;
    logic                   w_emit;
    logic [7:0]             w_data;
    logic                   w_last;
    logic [1:0]             w_status;
    logic [7:0]             w_key_byte;
    logic [LENGTH_BITS-1:0] w_left_dec;
    logic [LENGTH_BITS-1:0] w_left_shift;
    logic                   w_len_zero;

    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;

    assign w_left_dec   = r_left - LENGTH_BITS'(1);
    assign w_left_shift = {r_left[LENGTH_BITS-9:0], r_in_byte};

    always_comb begin
        case (r_kidx)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_hcnt     = r_hcnt;
        n_key      = r_key;
        n_mask_on  = r_mask_on;
        n_left     = r_left;
        n_kidx     = r_kidx;
        w_emit     = 1'b0;
        w_data     = 8'd0;
        w_last     = 1'b0;
        w_status   = wstfd_pkg::ST_PAYLOAD;
        w_len_zero = 1'b0;
        unique case (r_phase)
            wstfd_pkg::PH_SECOND: begin
                n_mask_on = r_in_byte[7];
                if (r_in_byte[6:0] == wstfd_pkg::LEN_EXT16) begin
                    n_left  = '0;
                    n_phase = wstfd_pkg::PH_EXTLEN;
                    n_hcnt  = wstfd_pkg::EXT16_CNT;
                end else if (r_in_byte[6:0] == wstfd_pkg::LEN_EXT64) begin
                    n_left  = '0;
                    n_phase = wstfd_pkg::PH_EXTLEN;
                    n_hcnt  = wstfd_pkg::EXT64_CNT;
                end else begin
                    n_left     = LENGTH_BITS'(r_in_byte[6:0]);
                    w_len_zero = (r_in_byte[6:0] == 7'd0);
                    if (r_in_byte[7]) begin
                        n_phase = wstfd_pkg::PH_KEY;
                        n_hcnt  = wstfd_pkg::KEY_CNT;
                        n_key   = '0;
                    end else begin
                        n_kidx = 2'd0;
                        if (w_len_zero) begin
                            n_phase  = wstfd_pkg::PH_FIRST;
                            w_emit   = 1'b1;
                            w_last   = 1'b1;
                            w_status = wstfd_pkg::ST_EMPTY;
                        end else begin
                            n_phase = wstfd_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
            wstfd_pkg::PH_EXTLEN: begin
                n_left     = w_left_shift;
                w_len_zero = (w_left_shift == '0);
                if (r_hcnt == 3'd0) begin
                    if (r_mask_on) begin
                        n_phase = wstfd_pkg::PH_KEY;
                        n_hcnt  = wstfd_pkg::KEY_CNT;
                        n_key   = '0;
                    end else begin
                        n_kidx = 2'd0;
                        if (w_len_zero) begin
                            n_phase  = wstfd_pkg::PH_FIRST;
                            w_emit   = 1'b1;
                            w_last   = 1'b1;
                            w_status = wstfd_pkg::ST_EMPTY;
                        end else begin
                            n_phase = wstfd_pkg::PH_PAYLOAD;
                        end
                    end
                end else begin
                    n_hcnt = r_hcnt - 3'd1;
                end
            end
            wstfd_pkg::PH_KEY: begin
                n_key = {r_key[23:0], r_in_byte};
                if (r_hcnt == 3'd0) begin
                    n_kidx = 2'd0;
                    if (r_left == '0) begin
                        n_phase  = wstfd_pkg::PH_FIRST;
                        w_emit   = 1'b1;
                        w_last   = 1'b1;
                        w_status = wstfd_pkg::ST_EMPTY;
                    end else begin
                        n_phase = wstfd_pkg::PH_PAYLOAD;
                    end
                end else begin
                    n_hcnt = r_hcnt - 3'd1;
                end
            end
            wstfd_pkg::PH_PAYLOAD: begin
                n_kidx   = r_kidx + 2'd1;
                n_left   = w_left_dec;
                w_emit   = 1'b1;
                w_data   = r_mask_on ? (r_in_byte ^ w_key_byte) : r_in_byte;
                w_last   = (w_left_dec == '0);
                w_status = wstfd_pkg::ST_PAYLOAD;
                if (w_left_dec == '0) begin
                    n_phase = wstfd_pkg::PH_FIRST;
                end
            end
            default: begin
                if (r_in_byte == wstfd_pkg::FIRST_HDR) begin
                    n_phase = wstfd_pkg::PH_SECOND;
                end else begin
                    n_phase  = wstfd_pkg::PH_FIRST;
                    w_emit   = 1'b1;
                    w_status = wstfd_pkg::ST_BAD;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall) begin
            r_in_byte <= i_stream_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= wstfd_pkg::PH_FIRST;
            r_hcnt    <= 3'd0;
            r_key     <= '0;
            r_mask_on <= 1'b0;
            r_left    <= '0;
            r_kidx    <= 2'd0;
        end else if (w_adv) begin
            r_phase   <= n_phase;
            r_hcnt    <= n_hcnt;
            r_key     <= n_key;
            r_mask_on <= n_mask_on;
            r_left    <= n_left;
            r_kidx    <= n_kidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid <= r_in_valid && w_emit;
        end
        if (w_adv && w_emit) begin
            r_data   <= w_data;
            r_last   <= w_last;
            r_status <= w_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_data;
    assign o_is_last   = r_last;
    assign o_status    = r_status;

    // checks
    a_bad_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == wstfd_pkg::ST_BAD) |-> (r_data == 8'd0 && !r_last))
        else $error("bad-header beat carries data or last");

    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == wstfd_pkg::ST_EMPTY) |-> (r_data == 8'd0 && r_last))
        else $error("empty-message beat malformed");

    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == wstfd_pkg::PH_PAYLOAD) |-> (r_left != '0))
        else $error("payload phase with no bytes left");

    a_key_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == wstfd_pkg::PH_KEY) |-> (r_hcnt <= wstfd_pkg::KEY_CNT && r_mask_on))
        else $error("key phase count out of range or mask off");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_emit && w_last) |=> (r_phase == wstfd_pkg::PH_FIRST))
        else $error("frame end did not return to first header byte");

endmodule
`default_nettype wire
